@@ design/bcg_pkg.sv @@
package bcg_pkg;

    // Field widths
    localparam int CLR_W          = 24;  // RGB888 word
    localparam int CH_W           = 8;   // one color channel
    localparam int NCH            = 3;   // channels per pixel
    localparam int RES_W          = 13;  // resolution registers
    localparam int NUM_W          = 21;  // holds 255 * 8191
    localparam int COORD_BITS_DEF = 12;

    // Configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_TL     = 3'd0;
    localparam logic [IDX_W-1:0] REG_TR     = 3'd1;
    localparam logic [IDX_W-1:0] REG_BL     = 3'd2;
    localparam logic [IDX_W-1:0] REG_BR     = 3'd3;
    localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd4;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd5;

    // Reset values
    localparam logic [CLR_W-1:0] RST_TL     = 24'h0000FF;
    localparam logic [CLR_W-1:0] RST_TR     = 24'h00FF00;
    localparam logic [CLR_W-1:0] RST_BL     = 24'hFF0000;
    localparam logic [CLR_W-1:0] RST_BR     = 24'hFFFF00;
    localparam logic [RES_W-1:0] RST_WIDTH  = 13'd640;
    localparam logic [RES_W-1:0] RST_HEIGHT = 13'd480;

endpackage

@@ design/bcg_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, several lanes
// sharing one divisor. The quotient must fit in Q_W bits.
module bcg_div
    import bcg_pkg::*;
#(
    parameter int LANES = NCH,
    parameter int NUM_W = bcg_pkg::NUM_W,
    parameter int DEN_W = RES_W,
    parameter int Q_W   = CH_W
)
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [LANES-1:0][NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0]            i_den,
    output logic                        o_valid,
    output logic [LANES-1:0][Q_W-1:0]   o_quo
);

    localparam int CMP_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [Q_W-1:0]                r_vld;
    logic [LANES-1:0][NUM_W-1:0]   r_rem [Q_W];
    logic [LANES-1:0][Q_W-1:0]     r_quo [Q_W];

    logic [Q_W-1:0]                s_vld;
    logic [LANES-1:0][NUM_W-1:0]   s_rem [Q_W];
    logic [LANES-1:0][Q_W-1:0]     s_quo [Q_W];
    logic [LANES-1:0][NUM_W-1:0]   n_rem [Q_W];
    logic [LANES-1:0][Q_W-1:0]     n_quo [Q_W];

    // Stage inputs: the first stage takes the port, the rest the stage before
    assign s_vld    = {r_vld[Q_W-2:0], i_valid};
    assign s_rem[0] = i_num;
    assign s_quo[0] = '0;
    for (genvar k = 1; k < Q_W; k++) begin : g_link
        assign s_rem[k] = r_rem[k-1];
        assign s_quo[k] = r_quo[k-1];
    end

    // One compare and subtract per stage and lane, MSB of the quotient first
    always_comb begin
        logic [CMP_W-1:0] d_sh;
        logic [CMP_W-1:0] rem;
        logic             ge;
        for (int k = 0; k < Q_W; k++) begin
            d_sh = CMP_W'(i_den) << (Q_W - 1 - k);
            for (int l = 0; l < LANES; l++) begin
                rem         = CMP_W'(s_rem[k][l]);
                ge          = (rem >= d_sh);
                n_rem[k][l] = ge ? NUM_W'(rem - d_sh) : s_rem[k][l];
                n_quo[k][l] = {s_quo[k][l][Q_W-2:0], ge};
            end
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= s_vld;
        end
    end

    // Partial remainders and quotients
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_valid = r_vld[Q_W-1];
    assign o_quo   = r_quo[Q_W-1];

endmodule

@@ design/bilinear_color_gradient.sv @@
// Bilinear color gradient: one RGB888 pixel per pixel coordinate.
// Setup: four corner colors and the two resolutions are written through
// the APB-style port (byte addresses 0x00..0x14); reads return them.
// Change them only while no pixel is in flight.
// Input: a coordinate word is taken at each rising edge with start high
// and busy low. busy is never raised, so one word can enter every clock.
// Output: o_done marks o_pixel_color for one cycle; the word is taken at
// the edge that ends that cycle. The pipeline is made of the clamp stage,
// two multiply stages, the two 8-stage divider pipelines (one per axis,
// one quotient bit per stage) and the output register. Throughput is
// one pixel per clock.
// The receiver cannot stall: results are never held or repeated.
// Reset (synchronous, active low) empties the pipeline and restores the
// default corner colors and a 640 x 480 resolution.
module bilinear_color_gradient
    import bcg_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    // coordinate channel
    input  logic                  start,
    output logic                  busy,
    input  logic [COORD_BITS-1:0] i_x_coord,
    input  logic [COORD_BITS-1:0] i_y_coord,
    // pixel channel
    output logic                  o_done,
    output logic [CLR_W-1:0]      o_pixel_color
);

    localparam int CMP_W     = (COORD_BITS > RES_W) ? COORD_BITS : RES_W;
    localparam int DIV_STEPS = CH_W;

    // Configuration registers
    logic [CLR_W-1:0] r_tl, r_tr, r_bl, r_br;
    logic [RES_W-1:0] r_width, r_height;
    logic [IDX_W-1:0] cfg_idx;
    logic             cfg_wr;

    assign cfg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel & penable & pwrite;
    assign pready  = 1'b1;
    assign busy    = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tl     <= RST_TL;
            r_tr     <= RST_TR;
            r_bl     <= RST_BL;
            r_br     <= RST_BR;
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_TL:     r_tl     <= pwdata[CLR_W-1:0];
                REG_TR:     r_tr     <= pwdata[CLR_W-1:0];
                REG_BL:     r_bl     <= pwdata[CLR_W-1:0];
                REG_BR:     r_br     <= pwdata[CLR_W-1:0];
                REG_WIDTH:  r_width  <= pwdata[RES_W-1:0];
                REG_HEIGHT: r_height <= pwdata[RES_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (cfg_idx)
            REG_TL:     prdata = DATA_W'(r_tl);
            REG_TR:     prdata = DATA_W'(r_tr);
            REG_BL:     prdata = DATA_W'(r_bl);
            REG_BR:     prdata = DATA_W'(r_br);
            REG_WIDTH:  prdata = DATA_W'(r_width);
            REG_HEIGHT: prdata = DATA_W'(r_height);
            default:    prdata = '0;
        endcase
    end

    // Effective resolutions: zero acts as one
    logic [RES_W-1:0] w_eff, h_eff;
    assign w_eff = (r_width  == '0) ? RES_W'(1) : r_width;
    assign h_eff = (r_height == '0) ? RES_W'(1) : r_height;

    // Stage 1: saturate coordinates to resolution minus one
    logic             accept;
    logic [CMP_W-1:0] x_ext, y_ext;
    logic [RES_W-1:0] n_s1_x, n_s1_y;
    logic             r_s1_valid;
    logic [RES_W-1:0] r_s1_x, r_s1_y;

    assign accept = start & ~busy;
    assign x_ext  = CMP_W'(i_x_coord);
    assign y_ext  = CMP_W'(i_y_coord);
    assign n_s1_x = (x_ext >= CMP_W'(w_eff)) ? w_eff - 1'b1 : x_ext[RES_W-1:0];
    assign n_s1_y = (y_ext >= CMP_W'(h_eff)) ? h_eff - 1'b1 : y_ext[RES_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_x <= n_s1_x;
        r_s1_y <= n_s1_y;
    end

    // Stage 2: x weighted sums, top row in lanes 0..2, bottom row in 3..5
    logic [RES_W-1:0]                    dx;
    logic [2*NCH-1:0][NUM_W-1:0]         n_xnum;
    logic [2*NCH-1:0][NUM_W-1:0]         r_xnum;
    logic                                r_s2_valid;
    logic [RES_W-1:0]                    r_s2_y;

    assign dx = w_eff - r_s1_x;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            n_xnum[c]     = NUM_W'(r_tl[c*CH_W +: CH_W]) * NUM_W'(dx)
                          + NUM_W'(r_tr[c*CH_W +: CH_W]) * NUM_W'(r_s1_x);
            n_xnum[c+NCH] = NUM_W'(r_bl[c*CH_W +: CH_W]) * NUM_W'(dx)
                          + NUM_W'(r_br[c*CH_W +: CH_W]) * NUM_W'(r_s1_x);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xnum <= n_xnum;
        r_s2_y <= r_s1_y;
    end

    // x divide by width
    logic                         xdiv_valid;
    logic [2*NCH-1:0][CH_W-1:0]   xq;

    bcg_div #(
        .LANES (2*NCH),
        .NUM_W (NUM_W),
        .DEN_W (RES_W),
        .Q_W   (CH_W)
    ) u_xdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_valid),
        .i_num   (r_xnum),
        .i_den   (w_eff),
        .o_valid (xdiv_valid),
        .o_quo   (xq)
    );

    // y follows the x divider through a delay line of equal length
    logic [RES_W-1:0] r_ydly [DIV_STEPS];

    always_ff @(posedge i_clk) begin
        r_ydly[0] <= r_s2_y;
        for (int k = 1; k < DIV_STEPS; k++) begin
            r_ydly[k] <= r_ydly[k-1];
        end
    end

    // Stage 3: y weighted sums between the top and bottom results
    logic [RES_W-1:0]            y_d, dy;
    logic [NCH-1:0][NUM_W-1:0]   n_ynum;
    logic [NCH-1:0][NUM_W-1:0]   r_ynum;
    logic                        r_s3_valid;

    assign y_d = r_ydly[DIV_STEPS-1];
    assign dy  = h_eff - y_d;

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            n_ynum[c] = NUM_W'(xq[c]) * NUM_W'(dy) + NUM_W'(xq[c+NCH]) * NUM_W'(y_d);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= xdiv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ynum <= n_ynum;
    end

    // y divide by height
    logic                     ydiv_valid;
    logic [NCH-1:0][CH_W-1:0] yq;

    bcg_div #(
        .LANES (NCH),
        .NUM_W (NUM_W),
        .DEN_W (RES_W),
        .Q_W   (CH_W)
    ) u_ydiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s3_valid),
        .i_num   (r_ynum),
        .i_den   (h_eff),
        .o_valid (ydiv_valid),
        .o_quo   (yq)
    );

    // Output register: blue in lane 0, red in lane 2
    logic             r_done;
    logic [CLR_W-1:0] r_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= ydiv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pixel <= CLR_W'(yq);
    end

    assign o_done        = r_done;
    assign o_pixel_color = r_pixel;

    // Every accepted word is followed by an o_done strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##20 o_done)
        else $error("pixel missing after accepted coordinate");

    // No strobe without a matching accepted word
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, 20))
        else $error("pixel strobe without accepted coordinate");

    // Row delay line must match the x divider depth
    a_ydly_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        xdiv_valid |-> $past(r_s2_valid, DIV_STEPS))
        else $error("x divider out of step with row delay line");

endmodule
